// File: src/zero_block_run_finder_top_defines.svh
// Assertion macros used by the checker file of the zero-block run finder.
`ifndef ZERO_BLOCK_RUN_FINDER_TOP_DEFINES_SVH
`define ZERO_BLOCK_RUN_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is asserted.
`define ZBRF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zero block run finder: assertion failed");

// Next-cycle implication, sampled on the rising clock, off while reset is asserted.
`define ZBRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zero block run finder: assertion failed");

`endif

// File: src/zbrf_pkg.sv
// Shared types and constants of the zero-block run finder.
package zbrf_pkg;

  localparam int unsigned CfgW     = 5;
  localparam int unsigned CfgReset = 12;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OffW     = 40;
  localparam int unsigned LenW     = 41;
  localparam int unsigned TdataW   = 88;
  localparam int unsigned PadW     = TdataW - OffW - LenW;

  // One result beat as produced by the scan core.
  typedef struct packed {
    logic            valid;
    logic            has_extent;
    logic            done_res;
    logic [OffW-1:0] extent_offset;
    logic [LenW-1:0] extent_length;
  } result_t;

endpackage

// File: src/zbrf_core.sv
// Scan state and per-byte next-state logic of the zero-block run finder.
module zbrf_core #(
  parameter int unsigned MAX_BLOCK_LOG2 = 16,
  parameter int unsigned POSITION_BITS  = 40,
  parameter int unsigned LgW            = $clog2(MAX_BLOCK_LOG2 + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      step_i,
  input  logic [zbrf_pkg::ByteW-1:0] data_byte_i,
  input  logic                      last_i,
  input  logic [LgW-1:0]            lg_i,
  output zbrf_pkg::result_t         result_o
);

  logic [MAX_BLOCK_LOG2-1:0] bib_q, bib_d;
  logic                      biz_q, biz_d;
  logic [POSITION_BITS-1:0]  pos_q, pos_d;
  logic [POSITION_BITS-1:0]  start_q, start_d;
  logic [POSITION_BITS-1:0]  len_q, len_d;
  logic                      in_run_q, in_run_d;

  logic [MAX_BLOCK_LOG2-1:0] idx_mask;
  logic [POSITION_BITS-1:0]  mask_ext;
  logic [POSITION_BITS-1:0]  blk_bytes;
  logic [POSITION_BITS-1:0]  pos_limit;
  logic                      zero;
  logic                      blk_end;
  logic                      end_emit;
  logic                      has_ext;
  logic [POSITION_BITS-1:0]  ext_off;
  logic [POSITION_BITS-1:0]  ext_len;

  // Thermometer decode of the block size: low lg bits set.
  always_comb begin
    for (int i = 0; i < MAX_BLOCK_LOG2; i++) begin
      idx_mask[i] = (LgW'(i) < lg_i);
    end
  end

  // Positions are kept in bytes; they stay aligned to the block size, so the
  // saturation limit is the all-ones position with the offset bits cleared.
  assign mask_ext  = POSITION_BITS'(idx_mask);
  assign blk_bytes = mask_ext + POSITION_BITS'(1);
  assign pos_limit = ~mask_ext;

  assign zero    = biz_q && (data_byte_i == '0);
  assign blk_end = (bib_q >= idx_mask);

  // Next state for one accepted byte.
  always_comb begin
    bib_d    = bib_q;
    biz_d    = biz_q;
    pos_d    = pos_q;
    start_d  = start_q;
    len_d    = len_q;
    in_run_d = in_run_q;
    end_emit = 1'b0;

    if (blk_end) begin
      if (pos_q < pos_limit) begin
        if (zero) begin
          if (!in_run_q) begin
            in_run_d = 1'b1;
            start_d  = pos_q;
            len_d    = blk_bytes;
          end else begin
            len_d = len_q + blk_bytes;
          end
        end else if (in_run_q) begin
          end_emit = 1'b1;
          in_run_d = 1'b0;
          len_d    = '0;
        end
        pos_d = pos_q + blk_bytes;
      end
      bib_d = '0;
      biz_d = 1'b1;
    end else begin
      bib_d = bib_q + MAX_BLOCK_LOG2'(1);
      biz_d = zero;
    end

    // A run closed by a nonzero block wins; otherwise the open run on the last byte.
    has_ext = end_emit || (last_i && in_run_d);
    ext_off = end_emit ? start_q : start_d;
    ext_len = end_emit ? len_q : len_d;
    if (!has_ext) begin
      ext_off = '0;
      ext_len = '0;
    end

    // The last byte returns the scan to its start for the next stream.
    if (last_i) begin
      bib_d    = '0;
      biz_d    = 1'b1;
      pos_d    = '0;
      start_d  = '0;
      len_d    = '0;
      in_run_d = 1'b0;
    end
  end

  assign result_o.valid         = end_emit || last_i;
  assign result_o.has_extent    = has_ext;
  assign result_o.done_res      = last_i;
  assign result_o.extent_offset = zbrf_pkg::OffW'(ext_off);
  assign result_o.extent_length = zbrf_pkg::LenW'(ext_len);

  // Scan state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bib_q    <= '0;
      biz_q    <= 1'b1;
      pos_q    <= '0;
      start_q  <= '0;
      len_q    <= '0;
      in_run_q <= 1'b0;
    end else if (clear_i) begin
      bib_q    <= '0;
      biz_q    <= 1'b1;
      pos_q    <= '0;
      start_q  <= '0;
      len_q    <= '0;
      in_run_q <= 1'b0;
    end else if (step_i) begin
      bib_q    <= bib_d;
      biz_q    <= biz_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      len_q    <= len_d;
      in_run_q <= in_run_d;
    end
  end

endmodule

// File: src/zero_block_run_finder_top.sv
// Top level of the zero-block run finder: stream ports, block size register, result register.
//
// The block takes one stream byte per beat and reports each maximal run of
// aligned all-zero blocks as one extent (byte offset, byte length). It accepts
// a byte in every cycle that the result register is free or being emptied; a
// result appears on the output in the cycle after the byte that causes it and
// is held in a result register, so a new byte is still taken while that result
// waits, as long as the result register is free or is being emptied in the same
// cycle. The per-byte state update (block byte counter, zero flag, position and
// run length adders) is combinational. A byte marked last always yields a
// result beat with tlast set. Writing the block size register restarts the
// scan and drops any open run; a value above MAX_BLOCK_LOG2 acts as MAX_BLOCK_LOG2.
// Positions saturate at POSITION_BITS bits: blocks past that point are ignored.
module zero_block_run_finder_top #(
  parameter int unsigned MAX_BLOCK_LOG2 = 16,
  parameter int unsigned POSITION_BITS  = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Block size register write channel.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [zbrf_pkg::CfgW-1:0]   cfg_data_i,      // block_size_log2
  // Byte stream in.
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [zbrf_pkg::ByteW-1:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  logic                        s_axis_tlast_i,  // last
  // Extent results out.
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [zbrf_pkg::TdataW-1:0] m_axis_tdata_o,  // [39:0] extent_offset,
                                                       // [80:40] extent_length, rest zero
  output logic                        m_axis_tuser_o,  // has_extent
  output logic                        m_axis_tlast_o   // done_res
);

  localparam int unsigned LgW = $clog2(MAX_BLOCK_LOG2 + 1);

  logic [zbrf_pkg::CfgW-1:0] cfg_q;
  logic [LgW-1:0]            lg;
  logic                      cfg_fire;
  logic                      in_fire;
  logic                      out_valid_q, out_valid_d;
  zbrf_pkg::result_t         res;
  zbrf_pkg::result_t         res_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Block size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= zbrf_pkg::CfgW'(zbrf_pkg::CfgReset);
    end else if (cfg_fire) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Clamp the block size to the largest supported one.
  assign lg = (cfg_q > zbrf_pkg::CfgW'(MAX_BLOCK_LOG2)) ? LgW'(MAX_BLOCK_LOG2)
                                                        : LgW'(cfg_q);

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  zbrf_core #(
    .MAX_BLOCK_LOG2(MAX_BLOCK_LOG2),
    .POSITION_BITS (POSITION_BITS),
    .LgW           (LgW)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (cfg_fire),
    .step_i     (in_fire),
    .data_byte_i(s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .lg_i       (lg),
    .result_o   (res)
  );

  // Result register: loaded by an accepted byte, emptied by an output beat.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = res.valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{zbrf_pkg::PadW{1'b0}}, res_q.extent_length, res_q.extent_offset};
  assign m_axis_tuser_o  = res_q.has_extent;
  assign m_axis_tlast_o  = res_q.done_res;

endmodule

// File: src/zbrf_checker.sv
// Port-level checker of the zero-block run finder and its bind to the top level.
`include "zero_block_run_finder_top_defines.svh"

module zbrf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic                        s_axis_tlast_i,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [zbrf_pkg::TdataW-1:0] m_axis_tdata_o,
  input logic                        m_axis_tuser_o,
  input logic                        m_axis_tlast_o
);

  // A stalled result beat keeps its contents.
  `ZBRF_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))

  // The input side only waits on a full, stalled result register.
  `ZBRF_ASSERT_NOW(a_in_stall, !s_axis_tready_o, m_axis_tvalid_o && !m_axis_tready_i)

  // The last byte always yields a done beat in the next cycle.
  `ZBRF_ASSERT_NEXT(a_last_done, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, m_axis_tvalid_o && m_axis_tlast_o)

  // Without an extent the payload is zero; with one the length is nonzero.
  `ZBRF_ASSERT_NOW(a_no_ext_zero, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o == '0)
  `ZBRF_ASSERT_NOW(a_ext_len, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o[80:40] != '0)

endmodule

bind zero_block_run_finder_top zbrf_checker u_zbrf_checker (.*);

// File: bench/zero_block_run_finder_top_test.sv
// Self-checking testbench for the zero-block run finder top level.
`timescale 1ns / 100ps

module zero_block_run_finder_top_test;

  localparam int unsigned MaxLog2      = 16;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned MaxShown     = 10;

  // One expected or observed result beat.
  typedef struct packed {
    logic [zbrf_pkg::OffW-1:0] ext_offset;
    logic [zbrf_pkg::LenW-1:0] ext_length;
    logic                      has_extent;
    logic                      done_res;
  } extent_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic [zbrf_pkg::CfgW-1:0]   cfg_data = '0;
  logic                        s_tvalid = 1'b0;
  logic [zbrf_pkg::ByteW-1:0]  s_tdata = '0;
  logic                        s_tlast = 1'b0;
  logic                        m_tready = 1'b0;
  logic                        cfg_ready_o;
  logic                        s_axis_tready_o;
  logic                        m_axis_tvalid_o;
  logic [zbrf_pkg::TdataW-1:0] m_axis_tdata_o;
  logic                        m_axis_tuser_o;
  logic                        m_axis_tlast_o;

  // Scan state as the block should hold it.
  logic [zbrf_pkg::CfgW-1:0]   blk_log2_reg = zbrf_pkg::CfgW'(zbrf_pkg::CfgReset);
  logic [15:0]                 pos_in_blk;
  logic                        blk_zero;
  logic [zbrf_pkg::OffW-1:0]   blk_idx;
  logic [zbrf_pkg::OffW-1:0]   run_first;
  logic [zbrf_pkg::OffW-1:0]   run_len;
  logic                        run_open;

  extent_t     expected_extents[$];
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned extents_seen = 0;
  int unsigned mismatches = 0;

  zero_block_run_finder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Clock: 2 ns high, 2 ns low.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result-side backpressure.
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic note_mismatch(input string what, input extent_t want, input extent_t got);
    mismatches++;
    if (mismatches <= MaxShown) begin
      $display("%0t: %s: expected off=%h len=%h ext=%b done=%b, got off=%h len=%h ext=%b done=%b",
               $realtime, what, want.ext_offset, want.ext_length, want.has_extent,
               want.done_res, got.ext_offset, got.ext_length, got.has_extent, got.done_res);
    end
  endtask

  // Result beats are sampled at the falling edge, where all signals are settled;
  // valid and ready high here means the beat moves at the next rising edge.
  always @(negedge clk_i) begin : check_results
    extent_t got;
    extent_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got.ext_offset = m_axis_tdata_o[zbrf_pkg::OffW-1:0];
      got.ext_length = m_axis_tdata_o[zbrf_pkg::OffW+zbrf_pkg::LenW-1:zbrf_pkg::OffW];
      got.has_extent = m_axis_tuser_o;
      got.done_res   = m_axis_tlast_o;
      beats_seen++;
      if (got.has_extent) extents_seen++;
      if (expected_extents.size() == 0) begin
        note_mismatch("result beat with nothing expected", '0, got);
      end else begin
        want = expected_extents.pop_front();
        if (got != want ||
            m_axis_tdata_o[zbrf_pkg::TdataW-1:zbrf_pkg::OffW+zbrf_pkg::LenW] != '0) begin
          note_mismatch("result beat differs", want, got);
        end
      end
    end
  end

  function automatic int unsigned eff_log2();
    return (blk_log2_reg > MaxLog2) ? MaxLog2 : int'(blk_log2_reg);
  endfunction

  task automatic clear_scan();
    pos_in_blk = '0;
    blk_zero   = 1'b1;
    blk_idx    = '0;
    run_first  = '0;
    run_len    = '0;
    run_open   = 1'b0;
  endtask

  // Advance the scan state by one byte and queue the result it causes, if any.
  task automatic predict_byte(input logic [zbrf_pkg::ByteW-1:0] b, input logic lst);
    int unsigned               lg;
    logic [16:0]               last_pos;
    logic [zbrf_pkg::OffW-1:0] limit;
    logic                      zero;
    logic                      emit;
    extent_t                   e;
    lg       = eff_log2();
    last_pos = (17'd1 << lg) - 17'd1;
    limit    = {zbrf_pkg::OffW{1'b1}} >> lg;
    zero     = blk_zero && (b == '0);
    emit     = 1'b0;
    e        = '0;
    if ({1'b0, pos_in_blk} >= last_pos) begin
      // Block completes here; saturated positions are ignored.
      if (blk_idx < limit) begin
        if (zero) begin
          if (!run_open) begin
            run_open  = 1'b1;
            run_first = blk_idx;
            run_len   = zbrf_pkg::OffW'(1);
          end else begin
            run_len++;
          end
        end else if (run_open) begin
          emit         = 1'b1;
          e.ext_offset = run_first << lg;
          e.ext_length = {1'b0, run_len} << lg;
          run_open     = 1'b0;
          run_len      = '0;
        end
        blk_idx++;
      end
      pos_in_blk = '0;
      blk_zero   = 1'b1;
    end else begin
      pos_in_blk++;
      blk_zero = zero;
    end
    // End of stream flushes an open run.
    if (lst && run_open) begin
      emit         = 1'b1;
      e.ext_offset = run_first << lg;
      e.ext_length = {1'b0, run_len} << lg;
    end
    if (emit || lst) begin
      e.has_extent = emit;
      e.done_res   = lst;
      expected_extents.push_back(e);
      if (lst) clear_scan();
    end
  endtask

  // Send one stream byte. Called right after a rising edge; returns right after
  // the edge at which the beat was taken. Valid stays high between back-to-back beats.
  task automatic send_byte(input logic [zbrf_pkg::ByteW-1:0] b, input logic lst);
    logic took;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    do begin
      @(negedge clk_i);
      took = s_axis_tready_o;
      @(posedge clk_i);
    end while (!took);
    bytes_sent++;
    predict_byte(b, lst);
  endtask

  task automatic send_zero_bytes(input int unsigned n, input logic lst_on_final);
    for (int unsigned i = 0; i < n; i++) begin
      send_byte('0, lst_on_final && (i == n - 1));
    end
  endtask

  // Hold the stream until every queued result has arrived or the wait limit runs out, then let the core settle.
  task automatic wait_for_extents(input int unsigned max_cycles);
    int unsigned n;
    n = 0;
    s_tvalid <= 1'b0;
    while (expected_extents.size() != 0 && n < max_cycles) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_block_size(input logic [zbrf_pkg::CfgW-1:0] v);
    logic took;
    wait_for_extents(200000);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_valid    <= 1'b0;
    blk_log2_reg = v;
    clear_scan();
  endtask

  // A well-formed stream: whole blocks, each all zero or with one hot byte,
  // sometimes followed by a partial block.
  task automatic send_random_stream(input int unsigned max_blocks);
    int unsigned sz;
    int unsigned nblk;
    int unsigned tail;
    int unsigned hot;
    logic [zbrf_pkg::ByteW-1:0] b;
    sz   = 1 << eff_log2();
    nblk = $urandom_range(max_blocks, 1);
    tail = (sz > 1 && $urandom_range(2) == 0) ? $urandom_range(sz - 1, 1) : 0;
    for (int unsigned k = 0; k < nblk; k++) begin
      hot = ($urandom_range(99) < 40) ? $urandom_range(sz - 1) : sz;
      for (int unsigned j = 0; j < sz; j++) begin
        b = (j == hot) ? zbrf_pkg::ByteW'($urandom_range(255, 1)) : '0;
        send_byte(b, tail == 0 && k == nblk - 1 && j == sz - 1);
      end
    end
    for (int unsigned j = 0; j < tail; j++) begin
      b = ($urandom_range(3) == 0) ? zbrf_pkg::ByteW'($urandom_range(255)) : '0;
      send_byte(b, j == tail - 1);
    end
  endtask

  // Unstructured bytes, half of them zero, ending with a last beat.
  task automatic send_noise_stream();
    int unsigned n;
    logic [zbrf_pkg::ByteW-1:0] b;
    n = $urandom_range(30, 1);
    for (int unsigned i = 0; i < n; i++) begin
      b = $urandom_range(1) ? zbrf_pkg::ByteW'($urandom_range(255)) : '0;
      send_byte(b, i == n - 1);
    end
  endtask

  // Reset value of the block size: a zero stream shorter than one 4 KiB block
  // gives only the end-of-stream beat.
  task automatic test_default_block_size();
    send_zero_bytes(100, 1'b1);
  endtask

  task automatic test_directed_cases();
    // Single-byte blocks: runs ended by nonzero bytes and by the last beat.
    write_block_size(zbrf_pkg::CfgW'(0));
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b1);
    // Two-byte blocks; a pause until all results are out, then a nonzero
    // block that ends the run on the last beat.
    write_block_size(zbrf_pkg::CfgW'(1));
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_zero_bytes(2, 1'b0);
    wait_for_extents(200000);
    send_zero_bytes(2, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b1);
    // An open run is dropped by a register write.
    send_zero_bytes(4, 1'b0);
    write_block_size(zbrf_pkg::CfgW'(2));
    send_zero_bytes(5, 1'b0);
    send_byte(8'h00, 1'b1);
    // A stream of one nonzero byte: only the end-of-stream beat.
    send_byte(8'h7F, 1'b1);
  endtask

  // Largest block size, and values above the limit that must act as it.
  task automatic test_block_size_extremes();
    write_block_size(zbrf_pkg::CfgW'(16));
    send_zero_bytes(5, 1'b1);
    write_block_size(zbrf_pkg::CfgW'(31));
    send_zero_bytes(6, 1'b0);
    send_byte(8'h01, 1'b1);
    write_block_size(zbrf_pkg::CfgW'(17));
    send_zero_bytes(3, 1'b1);
  endtask

  task automatic test_random_streams(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned lg;
    int unsigned n_streams;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      lg = ($urandom_range(9) == 0) ? $urandom_range(6, 5) : $urandom_range(4);
      write_block_size(zbrf_pkg::CfgW'(lg));
      n_streams = $urandom_range(6, 3);
      for (int unsigned s = 0; s < n_streams; s++) begin
        if (bytes_sent >= stop_at) break;
        if ($urandom_range(4) == 0) send_noise_stream();
        else send_random_stream(lg >= 4 ? 3 : 8);
      end
    end
  endtask

  initial begin
    clear_scan();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender idles lightly, receiver heavily.
    src_idle_pct = 18;
    snk_idle_pct = 76;
    test_default_block_size();
    test_directed_cases();
    test_random_streams(330);

    // Roles swapped.
    src_idle_pct = 76;
    snk_idle_pct = 18;
    test_random_streams(330);

    // Full rate both ways.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_block_size_extremes();
    test_random_streams(330);

    wait_for_extents(20000);
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_extents.size() != 0) begin
      mismatches += expected_extents.size();
      $display("%0d expected result beats never arrived", expected_extents.size());
    end
    $display("Sent %0d stream bytes, checked %0d result beats (%0d extents),",
             bytes_sent, beats_seen, extents_seen);
    $display("block sizes 1 B to 64 B, the reset size, values at and above the limit, three stall mixes.");
    if (mismatches == 0) begin
      $display("zero_block_run_finder_top regression: pass");
    end else begin
      $display("zero_block_run_finder_top regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #8000000;
    $display("Timed out waiting on the block.");
    $display("zero_block_run_finder_top regression: fail");
    $finish;
  end

endmodule
